[rtl/core/blkmm_pkg.sv]
// Shared types and constants for the blocked matrix multiply block.
// Used by blkmm_ctrl, blkmm_datapath and blocked_matrix_multiply; no dependencies.
`default_nettype none
package blkmm_pkg;

	localparam int ELEMENT_BITS = 16;
	localparam int PRODUCT_BITS = 35;
	localparam int STORE_DEPTH = 64;
	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int LOAD_W = ADDR_W + 1;
	localparam int CFG_W = 4;

	typedef enum logic [0:0] {
		REG_MATRIX_ORDER = 1'b0,
		REG_TILE_SIZE = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		STATUS_OK = 2'd0,
		STATUS_TILE_ZERO = 2'd1,
		STATUS_TILE_EXCEEDS = 2'd2,
		STATUS_TILE_NODIV = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [ELEMENT_BITS-1:0] a_element;
		logic signed [ELEMENT_BITS-1:0] b_element;
		logic final_pair;
	} pair_t;

	typedef struct packed {
		logic signed [PRODUCT_BITS-1:0] product_element;
		status_t status_code;
		logic end_of_run;
	} result_t;

	typedef struct packed {
		logic wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic rd_en;
		logic [ADDR_W-1:0] rd_a_addr;
		logic [ADDR_W-1:0] rd_b_addr;
		logic first_k;
		logic last_k;
		logic last_elem;
		logic err_en;
		status_t err_status;
	} cmd_t;

	typedef struct packed {
		logic run_done;
	} stat_t;

	// True when the tile size divides the order; valid for 1 <= t <= n <= 8.
	function automatic logic tile_divides(input logic [CFG_W-1:0] n, input logic [CFG_W-1:0] t);
		logic ok;
		ok = 1'b0;
		unique case (t)
			4'd1: ok = 1'b1;
			4'd2: ok = !n[0];
			4'd3: ok = (n == 4'd3) || (n == 4'd6);
			4'd4: ok = (n == 4'd4) || (n == 4'd8);
			4'd5: ok = (n == 4'd5);
			4'd6: ok = (n == 4'd6);
			4'd7: ok = (n == 4'd7);
			4'd8: ok = (n == 4'd8);
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

endpackage
`default_nettype wire

[rtl/core/blkmm_ctrl.sv]
// Controller for the blocked matrix multiply: configuration registers, load index,
// size check and the i/j/k sequencer. Depends on blkmm_pkg.
`default_nettype none
module blkmm_ctrl import blkmm_pkg::*; #(
	parameter int MAX_ORDER = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic final_pair,
	output logic busy,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire cfg_reg_t cfg_index,
	input wire logic [CFG_W-1:0] cfg_data,
	output cmd_t cmd,
	input wire stat_t stat
);

	localparam int IDX_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
	localparam logic [CFG_W-1:0] ORDER_LIMIT = CFG_W'(MAX_ORDER);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RUN = 4'b0010,
		ST_ERR = 4'b0100,
		ST_DRAIN = 4'b1000
	} state_t;

	state_t state_q;
	logic [CFG_W-1:0] matrix_order_q;
	logic [CFG_W-1:0] tile_size_q;
	logic [CFG_W-1:0] n_q;
	logic [LOAD_W-1:0] load_idx_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] j_q;
	logic [IDX_W-1:0] k_q;
	logic [ADDR_W-1:0] row_base_q;
	logic [ADDR_W-1:0] b_ptr_q;
	status_t err_q;

	logic accept;
	logic [CFG_W-1:0] n_clamp;
	status_t check;
	logic k_last;
	logic j_last;
	logic i_last;
	logic [ADDR_W-1:0] n_addr;

	assign cfg_ready = 1'b1;
	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign n_clamp = (matrix_order_q > ORDER_LIMIT) ? ORDER_LIMIT : matrix_order_q;
	assign n_addr = ADDR_W'(n_q);

	always_comb begin
		priority if (tile_size_q == '0) begin
			check = STATUS_TILE_ZERO;
		end else if (tile_size_q > n_clamp) begin
			check = STATUS_TILE_EXCEEDS;
		end else if (!tile_divides(n_clamp, tile_size_q)) begin
			check = STATUS_TILE_NODIV;
		end else begin
			check = STATUS_OK;
		end
	end

	assign k_last = (CFG_W'(k_q) == n_q - CFG_W'(1));
	assign j_last = (CFG_W'(j_q) == n_q - CFG_W'(1));
	assign i_last = (CFG_W'(i_q) == n_q - CFG_W'(1));

	always_comb begin
		cmd = '0;
		cmd.wr_en = accept && !load_idx_q[LOAD_W-1];
		cmd.wr_addr = load_idx_q[ADDR_W-1:0];
		cmd.rd_en = (state_q == ST_RUN);
		cmd.rd_a_addr = row_base_q + ADDR_W'(k_q);
		cmd.rd_b_addr = b_ptr_q;
		cmd.first_k = (k_q == '0);
		cmd.last_k = k_last;
		cmd.last_elem = k_last && j_last && i_last;
		cmd.err_en = (state_q == ST_ERR);
		cmd.err_status = err_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_order_q <= CFG_W'(8);
			tile_size_q <= CFG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MATRIX_ORDER: matrix_order_q <= cfg_data;
				REG_TILE_SIZE: tile_size_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_idx_q <= '0;
		end else if (accept) begin
			if (final_pair) begin
				load_idx_q <= '0;
			end else if (!load_idx_q[LOAD_W-1]) begin
				load_idx_q <= load_idx_q + LOAD_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q <= '0;
			err_q <= STATUS_OK;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			row_base_q <= '0;
			b_ptr_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && final_pair) begin
						n_q <= n_clamp;
						err_q <= check;
						i_q <= '0;
						j_q <= '0;
						k_q <= '0;
						row_base_q <= '0;
						b_ptr_q <= '0;
						state_q <= (check == STATUS_OK) ? ST_RUN : ST_ERR;
					end
				end
				ST_RUN: begin
					if (!k_last) begin
						k_q <= k_q + IDX_W'(1);
						b_ptr_q <= b_ptr_q + n_addr;
					end else begin
						k_q <= '0;
						if (!j_last) begin
							j_q <= j_q + IDX_W'(1);
							b_ptr_q <= ADDR_W'(j_q) + ADDR_W'(1);
						end else begin
							j_q <= '0;
							b_ptr_q <= '0;
							i_q <= i_q + IDX_W'(1);
							row_base_q <= row_base_q + n_addr;
							if (i_last) begin
								state_q <= ST_DRAIN;
							end
						end
					end
				end
				ST_ERR: begin
					state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (stat.run_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/core/blkmm_datapath.sv]
// Datapath for the blocked matrix multiply: A and B stores, multiplier,
// exact accumulator and the result register. Depends on blkmm_pkg.
`default_nettype none
module blkmm_datapath import blkmm_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire pair_t pair,
	input wire cmd_t cmd,
	output stat_t stat,
	output result_t result,
	output logic result_strobe
);

	logic [ELEMENT_BITS-1:0] a_mem [STORE_DEPTH];
	logic [ELEMENT_BITS-1:0] b_mem [STORE_DEPTH];

	logic signed [ELEMENT_BITS-1:0] a_rd_s1;
	logic signed [ELEMENT_BITS-1:0] b_rd_s1;
	logic vld_s1;
	logic first_s1;
	logic last_k_s1;
	logic end_s1;

	logic signed [2*ELEMENT_BITS-1:0] prod_s2;
	logic vld_s2;
	logic first_s2;
	logic last_k_s2;
	logic end_s2;

	logic signed [PRODUCT_BITS-1:0] acc_q;
	logic signed [PRODUCT_BITS-1:0] sum;
	result_t res_q;
	logic strobe_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			a_mem[cmd.wr_addr] <= pair.a_element;
			b_mem[cmd.wr_addr] <= pair.b_element;
		end
		if (cmd.rd_en) begin
			a_rd_s1 <= a_mem[cmd.rd_a_addr];
			b_rd_s1 <= b_mem[cmd.rd_b_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			first_s1 <= 1'b0;
			last_k_s1 <= 1'b0;
			end_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			first_s2 <= 1'b0;
			last_k_s2 <= 1'b0;
			end_s2 <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			vld_s1 <= cmd.rd_en;
			first_s1 <= cmd.first_k;
			last_k_s1 <= cmd.last_k;
			end_s1 <= cmd.last_elem;
			vld_s2 <= vld_s1;
			first_s2 <= first_s1;
			last_k_s2 <= last_k_s1;
			end_s2 <= end_s1;
			strobe_q <= (vld_s2 && last_k_s2) || cmd.err_en;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= a_rd_s1 * b_rd_s1;
	end

	assign sum = (first_s2 ? PRODUCT_BITS'(0) : acc_q) + PRODUCT_BITS'(prod_s2);

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			acc_q <= sum;
		end
		if (cmd.err_en) begin
			res_q.product_element <= '0;
			res_q.status_code <= cmd.err_status;
			res_q.end_of_run <= 1'b1;
		end else begin
			res_q.product_element <= sum;
			res_q.status_code <= STATUS_OK;
			res_q.end_of_run <= end_s2;
		end
	end

	assign result = res_q;
	assign result_strobe = strobe_q;
	assign stat.run_done = strobe_q && res_q.end_of_run;

endmodule
`default_nettype wire

[rtl/core/blocked_matrix_multiply.sv]
// Top level of the blocked matrix multiply.
// Instantiates blkmm_ctrl and blkmm_datapath; depends on blkmm_pkg.
//
// Element pairs load at one per cycle while busy is low; a pair is taken at a
// clock edge with start high and busy low. The pair with final_pair set raises
// busy and starts the product: a single multiplier fed by one read port of each
// store performs one multiply-accumulate per cycle, and each element of C passes
// through the read, multiply and output registers. A failed tile check gives
// its single result through the error state and the output register. Each
// result is on the result port for one cycle with result_strobe high; the
// receiver cannot stall the block.
// Store entries hold no reset value, and there is no clearing pass after reset.
`default_nettype none
module blocked_matrix_multiply import blkmm_pkg::*; #(
	parameter int MAX_ORDER = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire pair_t pair,
	output result_t result,
	output logic result_strobe,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire cfg_reg_t cfg_index,
	input wire logic [CFG_W-1:0] cfg_data
);

	cmd_t cmd;
	stat_t stat;

	blkmm_ctrl #(
		.MAX_ORDER(MAX_ORDER)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.final_pair(pair.final_pair),
		.busy(busy),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd(cmd),
		.stat(stat)
	);

	blkmm_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.pair(pair),
		.cmd(cmd),
		.stat(stat),
		.result(result),
		.result_strobe(result_strobe)
	);

endmodule
`default_nettype wire
